// ===== rtl/ptld_pkg.sv =====
package ptld_pkg;

    localparam int FRAC_BITS_DEF = 16;

    // numerator of the offset quotient: |a| * |E|
    localparam int NW = 96;
    // divisor and remainder width: a*a + b*b
    localparam int RW = 64;
    // quotient bits kept before rounding, anything at or above 2^QW is overflow
    localparam int QW = 35;
    // root bits of the distance square root
    localparam int SW = 32;
    // width of one squared offset
    localparam int SQ = 62;

    localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] S32_MIN = 32'h8000_0000;
    localparam logic [30:0] D31_MAX = 31'h7FFF_FFFF;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic               xneg;
        logic               yneg;
        logic               degen;
    } ptld_side_t;

    typedef struct packed {
        logic [31:0] fx;
        logic [31:0] fy;
        logic        sat;
        logic        degen;
        logic        dist_ovf;
    } ptld_tail_t;

endpackage

// ===== rtl/ptld_front.sv =====
module ptld_front #(
    parameter int FRAC_BITS = ptld_pkg::FRAC_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic signed [31:0]        a,
    input  logic signed [31:0]        b,
    input  logic signed [31:0]        c,
    input  logic signed [31:0]        px,
    input  logic signed [31:0]        py,
    output logic                      out_valid,
    output logic [ptld_pkg::NW-1:0]   num_x,
    output logic [ptld_pkg::NW-1:0]   num_y,
    output logic [ptld_pkg::RW-1:0]   den,
    output ptld_pkg::ptld_side_t      side
);
    import ptld_pkg::*;

    // stage 1: magnitudes and products
    logic               v1_reg;
    logic               an1_reg, bn1_reg, dg1_reg;
    logic [31:0]        ua1_reg, ub1_reg;
    logic signed [63:0] ax1_reg, by1_reg, cs1_reg;
    logic [63:0]        aa1_reg, bb1_reg;
    logic signed [31:0] px1_reg, py1_reg;
    logic [31:0]        ua_c, ub_c;

    // stage 2: denominator and signed numerator sum
    logic               v2_reg;
    logic [31:0]        ua2_reg, ub2_reg;
    logic [63:0]        emag2_reg;
    logic [RW-1:0]      den2_reg;
    ptld_side_t         side2_reg;
    logic signed [65:0] e_c;
    logic [63:0]        emag_c;

    // stage 3: partial products of |a|*|E| and |b|*|E|
    logic               v3_reg;
    logic [63:0]        pxl3_reg, pxh3_reg, pyl3_reg, pyh3_reg;
    logic [RW-1:0]      den3_reg;
    ptld_side_t         side3_reg;

    // stage 4: partial products combined
    logic               v4_reg;
    logic [NW-1:0]      nx4_reg, ny4_reg;
    logic [RW-1:0]      den4_reg;
    ptld_side_t         side4_reg;

    assign ua_c   = a[31] ? (~a + 32'd1) : a;
    assign ub_c   = b[31] ? (~b + 32'd1) : b;
    assign e_c    = 66'(ax1_reg) + 66'(by1_reg) + 66'(cs1_reg);
    assign emag_c = e_c[65] ? 64'(-e_c) : e_c[63:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            an1_reg <= a[31];
            bn1_reg <= b[31];
            dg1_reg <= (a == 32'sd0) && (b == 32'sd0);
            ua1_reg <= ua_c;
            ub1_reg <= ub_c;
            ax1_reg <= 64'(a) * 64'(px);
            by1_reg <= 64'(b) * 64'(py);
            cs1_reg <= 64'(c) <<< FRAC_BITS;
            aa1_reg <= 64'(ua_c) * 64'(ua_c);
            bb1_reg <= 64'(ub_c) * 64'(ub_c);
            px1_reg <= px;
            py1_reg <= py;

            ua2_reg         <= ua1_reg;
            ub2_reg         <= ub1_reg;
            emag2_reg       <= emag_c;
            den2_reg        <= aa1_reg + bb1_reg;
            side2_reg.px    <= px1_reg;
            side2_reg.py    <= py1_reg;
            side2_reg.xneg  <= an1_reg ^ e_c[65];
            side2_reg.yneg  <= bn1_reg ^ e_c[65];
            side2_reg.degen <= dg1_reg;

            pxl3_reg  <= 64'(ua2_reg) * 64'(emag2_reg[31:0]);
            pxh3_reg  <= 64'(ua2_reg) * 64'(emag2_reg[63:32]);
            pyl3_reg  <= 64'(ub2_reg) * 64'(emag2_reg[31:0]);
            pyh3_reg  <= 64'(ub2_reg) * 64'(emag2_reg[63:32]);
            den3_reg  <= den2_reg;
            side3_reg <= side2_reg;

            nx4_reg   <= NW'(pxl3_reg) + {pxh3_reg, 32'd0};
            ny4_reg   <= NW'(pyl3_reg) + {pyh3_reg, 32'd0};
            den4_reg  <= den3_reg;
            side4_reg <= side3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign num_x     = nx4_reg;
    assign num_y     = ny4_reg;
    assign den       = den4_reg;
    assign side      = side4_reg;

endmodule

// ===== rtl/ptld_div.sv =====
module ptld_div (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [ptld_pkg::NW-1:0] num_x,
    input  logic [ptld_pkg::NW-1:0] num_y,
    input  logic [ptld_pkg::RW-1:0] den,
    input  ptld_pkg::ptld_side_t    side_in,
    output logic                    out_valid,
    output logic [ptld_pkg::QW:0]   qx,
    output logic [ptld_pkg::QW:0]   qy,
    output logic                    ovf_x,
    output logic                    ovf_y,
    output ptld_pkg::ptld_side_t    side_out
);
    import ptld_pkg::*;

    logic             v_reg    [0:QW];
    logic [RW-1:0]    rx_reg   [0:QW];
    logic [RW-1:0]    ry_reg   [0:QW];
    logic [QW-1:0]    lx_reg   [0:QW];
    logic [QW-1:0]    ly_reg   [0:QW];
    logic [QW-1:0]    qx_reg   [0:QW];
    logic [QW-1:0]    qy_reg   [0:QW];
    logic             ox_reg   [0:QW];
    logic             oy_reg   [0:QW];
    logic [RW-1:0]    den_reg  [0:QW];
    ptld_side_t       side_reg [0:QW];

    logic             vr_reg;
    logic [QW:0]      qxr_reg, qyr_reg;
    logic             oxr_reg, oyr_reg;
    ptld_side_t       sider_reg;
    logic             upx_c, upy_c;

    // setup: the high part of the numerator is the first partial remainder,
    // quotient overflows when it already reaches the divisor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rx_reg[0]   <= RW'(num_x[NW-1:QW]);
            ry_reg[0]   <= RW'(num_y[NW-1:QW]);
            lx_reg[0]   <= num_x[QW-1:0];
            ly_reg[0]   <= num_y[QW-1:0];
            qx_reg[0]   <= '0;
            qy_reg[0]   <= '0;
            ox_reg[0]   <= RW'(num_x[NW-1:QW]) >= den;
            oy_reg[0]   <= RW'(num_y[NW-1:QW]) >= den;
            den_reg[0]  <= den;
            side_reg[0] <= side_in;
        end
    end

    // one restoring step per stage, one quotient bit per lane
    for (genvar k = 0; k < QW; k++)
    begin : g_step
        logic [RW:0] tx, ty;
        logic        gx, gy;

        assign tx = {rx_reg[k], lx_reg[k][QW-1]};
        assign ty = {ry_reg[k], ly_reg[k][QW-1]};
        assign gx = tx >= {1'b0, den_reg[k]};
        assign gy = ty >= {1'b0, den_reg[k]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k+1] <= v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rx_reg[k+1]   <= gx ? RW'(tx - {1'b0, den_reg[k]}) : tx[RW-1:0];
                ry_reg[k+1]   <= gy ? RW'(ty - {1'b0, den_reg[k]}) : ty[RW-1:0];
                lx_reg[k+1]   <= lx_reg[k] << 1;
                ly_reg[k+1]   <= ly_reg[k] << 1;
                qx_reg[k+1]   <= {qx_reg[k][QW-2:0], gx};
                qy_reg[k+1]   <= {qy_reg[k][QW-2:0], gy};
                ox_reg[k+1]   <= ox_reg[k];
                oy_reg[k+1]   <= oy_reg[k];
                den_reg[k+1]  <= den_reg[k];
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    // round half up: remainder at least half the divisor
    assign upx_c = {rx_reg[QW], 1'b0} >= {1'b0, den_reg[QW]};
    assign upy_c = {ry_reg[QW], 1'b0} >= {1'b0, den_reg[QW]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vr_reg <= 1'b0;
        end
        else if (en)
        begin
            vr_reg <= v_reg[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qxr_reg   <= {1'b0, qx_reg[QW]} + (QW+1)'(upx_c);
            qyr_reg   <= {1'b0, qy_reg[QW]} + (QW+1)'(upy_c);
            oxr_reg   <= ox_reg[QW];
            oyr_reg   <= oy_reg[QW];
            sider_reg <= side_reg[QW];
        end
    end

    assign out_valid = vr_reg;
    assign qx        = qxr_reg;
    assign qy        = qyr_reg;
    assign ovf_x     = oxr_reg;
    assign ovf_y     = oyr_reg;
    assign side_out  = sider_reg;

endmodule

// ===== rtl/ptld_sqrt.sv =====
module ptld_sqrt (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [ptld_pkg::SQ-1:0] sq_a,
    input  logic [ptld_pkg::SQ-1:0] sq_b,
    input  ptld_pkg::ptld_tail_t    tail_in,
    output logic                    out_valid,
    output logic [ptld_pkg::SW-1:0] root,
    output ptld_pkg::ptld_tail_t    tail_out
);
    import ptld_pkg::*;

    logic          v_reg    [0:SW];
    logic [63:0]   rem_reg  [0:SW];
    logic [SW-1:0] r_reg    [0:SW];
    ptld_tail_t    tail_reg [0:SW];

    logic          vo_reg;
    logic [SW-1:0] root_reg;
    ptld_tail_t    tailo_reg;
    logic          up_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= 64'(sq_a) + 64'(sq_b);
            r_reg[0]    <= '0;
            tail_reg[0] <= tail_in;
        end
    end

    // digit-by-digit root, most significant bit first; rem holds n - r*r
    for (genvar k = 0; k < SW; k++)
    begin : g_bit
        localparam int I = SW - 1 - k;
        logic [65:0] sub;
        logic        take;

        assign sub  = (66'(r_reg[k]) << (I + 1)) + (66'(1) << (2 * I));
        assign take = {2'b00, rem_reg[k]} >= sub;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k+1] <= v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]  <= take ? (rem_reg[k] - sub[63:0]) : rem_reg[k];
                r_reg[k+1]    <= take ? (r_reg[k] | (SW'(1) << I)) : r_reg[k];
                tail_reg[k+1] <= tail_reg[k];
            end
        end
    end

    // round to nearest: step up when n - s*s exceeds s
    assign up_c = rem_reg[SW] > 64'(r_reg[SW]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vo_reg <= 1'b0;
        end
        else if (en)
        begin
            vo_reg <= v_reg[SW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            root_reg  <= r_reg[SW] + SW'(up_c);
            tailo_reg <= tail_reg[SW];
        end
    end

    assign out_valid = vo_reg;
    assign root      = root_reg;
    assign tail_out  = tailo_reg;

endmodule

// ===== rtl/point_to_line_distance.sv =====
// point_to_line_distance
//
// Takes a line a*x + b*y + c = 0 and a point (point_x, point_y), all signed
// fixed point with FRAC_BITS fraction bits, and returns the foot of the
// perpendicular from the point to the line together with the distance.
// Input and output are valid/ready channels; one beat in gives one beat out,
// in order. A line with a = b = 0 returns zero fields with degenerate set.
// Out-of-range results are clamped and flagged on saturated.
//
// From input beat to output beat a query passes the multiplies and sums,
// the two-lane restoring divider (one quotient bit per stage), the
// register for the foot and the squares, the bit-per-stage square root
// and 1 output register.
// A new beat is taken every cycle while the output is free or being taken.
//
// When out_ready is low with a result waiting, the whole pipeline holds and
// in_ready drops; nothing in flight is lost or repeated.
// Reset clears every valid flag, so the block comes up empty and ready.
module point_to_line_distance #(
    parameter int FRAC_BITS = ptld_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] line_a,
    input  logic signed [31:0] line_b,
    input  logic signed [31:0] line_c,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] foot_x,
    output logic signed [31:0] foot_y,
    output logic [30:0]        distance,
    output logic               degenerate,
    output logic               saturated
);
    import ptld_pkg::*;

    // returns {clamped, value} for p moved by an offset of magnitude q
    function automatic logic [32:0] foot_calc(
        input logic signed [31:0] p,
        input logic               neg,
        input logic [QW:0]        q,
        input logic               ovf
    );
        logic signed [QW+1:0] pe;
        logic signed [QW+1:0] qe;
        logic signed [QW+1:0] f;
        logic [32:0]          r;
        pe = (QW+2)'(p);
        qe = $signed({1'b0, q});
        f  = neg ? (pe + qe) : (pe - qe);
        if (ovf || (q[QW:QW-1] != 2'b00))
        begin
            r = {1'b1, (neg ? S32_MAX : S32_MIN)};
        end
        else if ((&f[QW+1:31]) || !(|f[QW+1:31]))
        begin
            r = {1'b0, f[31:0]};
        end
        else
        begin
            r = {1'b1, (f[QW+1] ? S32_MIN : S32_MAX)};
        end
        return r;
    endfunction

    logic            en;
    logic            fr_valid;
    logic [NW-1:0]   fr_nx, fr_ny;
    logic [RW-1:0]   fr_den;
    ptld_side_t      fr_side;

    logic            dv_valid;
    logic [QW:0]     dv_qx, dv_qy;
    logic            dv_ox, dv_oy;
    ptld_side_t      dv_side;

    logic [32:0]     fx_c, fy_c;
    logic            dovf_c;

    logic            ft_v_reg;
    ptld_tail_t      ft_tail_reg;
    logic [SQ-1:0]   sqx_reg, sqy_reg;

    logic            sq_valid;
    logic [SW-1:0]   sq_root;
    ptld_tail_t      sq_tail;

    logic            out_valid_reg;
    logic [31:0]     fx_reg, fy_reg;
    logic [30:0]     dist_reg;
    logic            degen_reg, sat_reg;
    logic            dsat_c;

    // the whole pipeline advances unless a finished beat is being held
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    ptld_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .a         (line_a),
        .b         (line_b),
        .c         (line_c),
        .px        (point_x),
        .py        (point_y),
        .out_valid (fr_valid),
        .num_x     (fr_nx),
        .num_y     (fr_ny),
        .den       (fr_den),
        .side      (fr_side)
    );

    ptld_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fr_valid),
        .num_x     (fr_nx),
        .num_y     (fr_ny),
        .den       (fr_den),
        .side_in   (fr_side),
        .out_valid (dv_valid),
        .qx        (dv_qx),
        .qy        (dv_qy),
        .ovf_x     (dv_ox),
        .ovf_y     (dv_oy),
        .side_out  (dv_side)
    );

    assign fx_c   = foot_calc(dv_side.px, dv_side.xneg, dv_qx, dv_ox);
    assign fy_c   = foot_calc(dv_side.py, dv_side.yneg, dv_qy, dv_oy);
    // an offset of 2^31 or more pins the distance at full scale
    assign dovf_c = dv_ox || dv_oy || (|dv_qx[QW:31]) || (|dv_qy[QW:31]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ft_v_reg <= 1'b0;
        end
        else if (en)
        begin
            ft_v_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ft_tail_reg.fx       <= fx_c[31:0];
            ft_tail_reg.fy       <= fy_c[31:0];
            ft_tail_reg.sat      <= fx_c[32] | fy_c[32] | dovf_c;
            ft_tail_reg.degen    <= dv_side.degen;
            ft_tail_reg.dist_ovf <= dovf_c;
            sqx_reg              <= SQ'(dv_qx[30:0]) * SQ'(dv_qx[30:0]);
            sqy_reg              <= SQ'(dv_qy[30:0]) * SQ'(dv_qy[30:0]);
        end
    end

    ptld_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (ft_v_reg),
        .sq_a      (sqx_reg),
        .sq_b      (sqy_reg),
        .tail_in   (ft_tail_reg),
        .out_valid (sq_valid),
        .root      (sq_root),
        .tail_out  (sq_tail)
    );

    assign dsat_c = sq_tail.dist_ovf || sq_root[SW-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= sq_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (sq_tail.degen)
            begin
                fx_reg    <= '0;
                fy_reg    <= '0;
                dist_reg  <= '0;
                degen_reg <= 1'b1;
                sat_reg   <= 1'b0;
            end
            else
            begin
                fx_reg    <= sq_tail.fx;
                fy_reg    <= sq_tail.fy;
                dist_reg  <= dsat_c ? D31_MAX : sq_root[30:0];
                degen_reg <= 1'b0;
                sat_reg   <= sq_tail.sat | dsat_c;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign foot_x     = fx_reg;
    assign foot_y     = fy_reg;
    assign distance   = dist_reg;
    assign degenerate = degen_reg;
    assign saturated  = sat_reg;

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    localparam int FRAC = 16;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 200;

    typedef struct {
        logic signed [31:0] fx;
        logic signed [31:0] fy;
        logic [30:0]        dist_val;
        logic               degen;
        logic               sat;
    } foot_t;

    // rounded |n| / d, halves away from zero
    function automatic logic [127:0] div_round(logic [127:0] n, logic [127:0] d);
        logic [127:0] q;
        logic [127:0] r;
        begin
            q = n / d;
            r = n % d;
            if (r >= d - r)
                q = q + 1;
            return q;
        end
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bitv;
        begin
            res = 0;
            bitv = 64'h1 << 62;
            while (bitv > n)
                bitv = bitv >> 2;
            while (bitv != 0)
            begin
                if (n >= res + bitv)
                begin
                    n = n - (res + bitv);
                    res = (res >> 1) + bitv;
                end
                else
                    res = res >> 1;
                bitv = bitv >> 2;
            end
            return res;
        end
    endfunction

    function automatic logic signed [31:0] clamp_foot(logic signed [31:0] p, logic neg,
                                                       logic [127:0] q, ref logic sat);
        logic signed [63:0] f;
        begin
            if (q >= (128'h1 << 34))
            begin
                sat = 1'b1;
                return neg ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            end
            f = neg ? 64'(p) + $signed(64'(q)) : 64'(p) - $signed(64'(q));
            if (f > 64'sh7FFF_FFFF)
            begin
                sat = 1'b1;
                return 32'sh7FFF_FFFF;
            end
            if (f < -64'sh8000_0000)
            begin
                sat = 1'b1;
                return 32'sh8000_0000;
            end
            return f[31:0];
        end
    endfunction

    function automatic foot_t predict_foot(logic signed [31:0] a, logic signed [31:0] b,
                                           logic signed [31:0] c, logic signed [31:0] px,
                                           logic signed [31:0] py);
        foot_t r;
        logic [63:0] ua;
        logic [63:0] ub;
        logic [127:0] d;
        logic signed [127:0] e;
        logic [127:0] emag;
        logic eneg;
        logic [127:0] qx;
        logic [127:0] qy;
        logic [63:0] n;
        logic [63:0] s;
        logic sat;
        begin
            r = '{default: '0};
            ua = a < 0 ? 64'(-64'(a)) : 64'(a);
            ub = b < 0 ? 64'(-64'(b)) : 64'(b);
            d = 128'(ua * ua) + 128'(ub * ub);
            if (d == 0)
            begin
                r.degen = 1'b1;
                return r;
            end
            e = 128'(a) * 128'(px) + 128'(b) * 128'(py) + (128'(c) <<< FRAC);
            eneg = e < 0;
            emag = eneg ? 128'(-e) : 128'(e);
            qx = div_round(128'(ua) * emag, d);
            qy = div_round(128'(ub) * emag, d);
            sat = 1'b0;
            r.fx = clamp_foot(px, (a < 0) != eneg, qx, sat);
            r.fy = clamp_foot(py, (b < 0) != eneg, qy, sat);
            if (qx > 128'h7FFF_FFFF || qy > 128'h7FFF_FFFF)
            begin
                r.dist_val = 31'h7FFF_FFFF;
                sat = 1'b1;
            end
            else
            begin
                n = qx[63:0] * qx[63:0] + qy[63:0] * qy[63:0];
                s = int_sqrt(n);
                if (n - s * s > s)
                    s = s + 1;
                if (s > 64'h7FFF_FFFF)
                begin
                    s = 64'h7FFF_FFFF;
                    sat = 1'b1;
                end
                r.dist_val = s[30:0];
            end
            r.sat = sat;
            return r;
        end
    endfunction

    class foot_board;
        foot_t pending[$];
        int mismatches;

        function new();
            mismatches = 0;
        endfunction

        function void note_query(logic signed [31:0] a, logic signed [31:0] b,
                                 logic signed [31:0] c, logic signed [31:0] px,
                                 logic signed [31:0] py);
            pending.insert(pending.size(), predict_foot(a, b, c, px, py));
        endfunction

        function void check_foot(foot_t got);
            foot_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: fx %h fy %h d %h",
                             got.fx, got.fy, got.dist_val);
                return;
            end
            want = pending.pop_front();
            if (got.fx !== want.fx || got.fy !== want.fy || got.dist_val !== want.dist_val ||
                got.degen !== want.degen || got.sat !== want.sat)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: want %h %h %h %b %b got %h %h %h %b %b",
                             want.fx, want.fy, want.dist_val, want.degen, want.sat,
                             got.fx, got.fy, got.dist_val, got.degen, got.sat);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [31:0] line_a = '0;
    logic signed [31:0] line_b = '0;
    logic signed [31:0] line_c = '0;
    logic signed [31:0] point_x = '0;
    logic signed [31:0] point_y = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [31:0] foot_x;
    logic signed [31:0] foot_y;
    logic [30:0] distance;
    logic degenerate;
    logic saturated;

    foot_board board = new();
    int send_idle = 0;
    int recv_stall = 0;
    logic hold_off = 1'b0;
    int idle_cycles = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    point_to_line_distance dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .line_a(line_a), .line_b(line_b), .line_c(line_c),
        .point_x(point_x), .point_y(point_y),
        .out_valid(out_valid), .out_ready(out_ready),
        .foot_x(foot_x), .foot_y(foot_y), .distance(distance),
        .degenerate(degenerate), .saturated(saturated)
    );

    // receiver: random stalls, plus the long hold-off
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                board.check_foot('{foot_x, foot_y, distance, degenerate, saturated});
            out_ready <= !hold_off && ($urandom_range(99) >= recv_stall);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic logic signed [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom();
            1: return $signed(32'($urandom_range(65535 * 64))) - 32'sd2097120;
            2: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: return $signed(32'($urandom_range(2048))) - 32'sd1024;
        endcase
    endfunction

    // valid stays up between back-to-back beats and drops only for idle gaps
    task automatic send_query(logic signed [31:0] a, logic signed [31:0] b,
                              logic signed [31:0] c, logic signed [31:0] px,
                              logic signed [31:0] py);
        if ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle);
        end
        in_valid <= 1'b1;
        line_a <= a;
        line_b <= b;
        line_c <= c;
        point_x <= px;
        point_y <= py;
        do
            @(posedge clk);
        while (!in_ready);
        board.note_query(a, b, c, px, py);
    endtask

    task automatic send_random(int count);
        int m;
        for (int i = 0; i < count; i++)
        begin
            m = $urandom_range(3);
            if ($urandom_range(19) == 0)
                send_query(0, 0, rand_coord(0), rand_coord(0), rand_coord(0));
            else
                send_query(rand_coord(m), rand_coord(m), rand_coord($urandom_range(3)),
                           rand_coord($urandom_range(3)), rand_coord($urandom_range(3)));
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: degenerate line, axis lines, extremes, point on line
        send_query(0, 0, 0, 0, 0);
        send_query(0, 0, 32'sh7FFF_FFFF, 32'sh1234, -32'sh5678);
        send_query(32'sh10000, 0, 0, 32'sh30000, 32'sh20000);
        send_query(0, 32'sh10000, -32'sh10000, 32'sh30000, 32'sh20000);
        send_query(32'sh10000, 32'sh10000, 0, 32'sh10000, -32'sh10000);
        send_query(32'sh10000, -32'sh10000, 32'sh8000, 0, 0);
        send_query(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                   32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_query(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                   32'sh8000_0000, 32'sh8000_0000);
        send_query(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                   32'sh7FFF_FFFF, 32'sh8000_0000);
        send_query(1, 0, 32'sh7FFF_FFFF, 0, 0);
        send_query(0, 1, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
        send_query(1, 1, 0, 1, 0);
        send_query(3, 4, 0, 32'sh50000, 0);
        send_query(-1, -1, -1, -1, -1);
        send_query(32'sh1, 32'sh7FFF_FFFF, 0, 32'sh7FFF_FFFF, 0);

        send_idle = 0; recv_stall = 0;
        send_random(300);
        send_idle = 81; recv_stall = 0;
        send_random(200);
        send_idle = 0; recv_stall = 81;
        send_random(200);
        send_idle = 11; recv_stall = 11;
        send_random(200);

        // long receiver hold-off so the pipeline fills and stalls its input
        send_idle = 0; recv_stall = 0;
        fork
            begin
                hold_off <= 1'b1;
                repeat (400) @(posedge clk);
                hold_off <= 1'b0;
            end
            send_random(200);
        join
        in_valid <= 1'b0;

        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/ptld_pkg.sv
rtl/ptld_front.sv
rtl/ptld_div.sv
rtl/ptld_sqrt.sv
rtl/point_to_line_distance.sv
sim/tb_top.sv
